FILE: src/rprm_pkg.sv
// ----------------------------------------------------------------------------
// rprm_pkg: shared types and constants of the reciprocal pulse-rate meter
// Holds the controller states, request and register codes, and field widths.
// ----------------------------------------------------------------------------
package rprm_pkg;

   // Default width of the pulse counter.
   localparam int PULSE_COUNT_BITS_DEF = 16;

   // Field widths.
   localparam int GAIN_W   = 24;
   localparam int OFFSET_W = 32;
   localparam int TPO_W    = 9;
   localparam int TICK_W   = 8;
   localparam int TS_W     = 16;
   localparam int RATE_W   = 40;
   localparam int CONST_W  = 13;
   localparam int SCALE_W  = GAIN_W + CONST_W;
   localparam int QUOT_W   = 42;
   localparam int SUM_W    = 44;

   // Rate constant of the meter.
   localparam logic [CONST_W-1:0] RATE_CONST = CONST_W'(7800);

   // Largest positive Q24.16 rate.
   localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};

   // Request kinds.
   localparam logic [1:0] ACT_PULSE   = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_FLOW_GAIN   = 2'd0;
   localparam logic [1:0] CSR_FLOW_OFFSET = 2'd1;
   localparam logic [1:0] CSR_TICKS_OVF   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

FILE: src/reciprocal_pulse_rate_meter_top.sv
// ----------------------------------------------------------------------------
// reciprocal_pulse_rate_meter_top: reciprocal pulse-rate meter
// Counts pulse edges, timestamps the first and the latest edge, and on a read
// reports gain * 7800 * (pulses - 1) / interval + offset with saturation.
// ----------------------------------------------------------------------------
// Pulse and restart requests produce no result. A read runs a load step, a
// one-bit-per-cycle multiply over the pulse count, a one-bit-per-cycle divide
// over the 37 + PULSE_COUNT_BITS bit product and a result step that waits while
// an earlier result is unaccepted; too few pulses or a zero interval skip from
// load to result. No request is taken until a read's result is registered.
// Synchronous reset clears control and pulse state and sets register defaults.
module reciprocal_pulse_rate_meter_top #(
   parameter int PULSE_COUNT_BITS = rprm_pkg::PULSE_COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] timer_count, [15:8] overflow_count
   input  logic [1:0]  req_tuser,   // [1:0] action
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [39:0] rate
   output logic [1:0]  rsp_tuser,   // [0] rate_valid, [1] saturated
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int P     = PULSE_COUNT_BITS;
   localparam int NW    = rprm_pkg::SCALE_W + P;
   localparam int CNT_W = $clog2(NW);
   localparam int SW    = rprm_pkg::SCALE_W;
   localparam int TS_W  = rprm_pkg::TS_W;
   localparam int QW    = rprm_pkg::QUOT_W;

   localparam logic [SW-1:0] RATE_CONST_EXT = SW'(rprm_pkg::RATE_CONST);

   rprm_pkg::state_type state_ff, state_in;

   // Registers.
   logic [rprm_pkg::GAIN_W-1:0]          gain_ff;
   logic signed [rprm_pkg::OFFSET_W-1:0] offset_ff;
   logic [rprm_pkg::TPO_W-1:0]           tpo_ff;

   // Pulse state.
   logic [P-1:0]                 pulse_cnt_ff, pulse_cnt_in;
   logic [rprm_pkg::TICK_W-1:0]  first_tick_ff, first_tick_in;
   logic [rprm_pkg::TICK_W-1:0]  first_ovf_ff, first_ovf_in;
   logic [rprm_pkg::TICK_W-1:0]  last_tick_ff, last_tick_in;
   logic [rprm_pkg::TICK_W-1:0]  last_ovf_ff, last_ovf_in;

   // Arithmetic datapath.
   logic [SW-1:0]    scale_ff, scale_in;
   logic [TS_W-1:0]  div_ff, div_in;
   logic [NW-1:0]    prod_ff, prod_in;
   logic [TS_W-1:0]  rem_ff, rem_in;
   logic [QW-1:0]    quot_ff, quot_in;
   logic             qbig_ff, qbig_in;
   logic             res_ok_ff, res_ok_in;
   logic [CNT_W-1:0] step_ff, step_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [rprm_pkg::RATE_W-1:0] rsp_rate_ff, rsp_rate_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   logic req_fire;
   logic out_free;

   // Combinational helpers.
   logic [16:0]            ovf_last_mul, ovf_first_mul;
   logic [TS_W-1:0]        ts_last, ts_first, interval;
   logic [SW:0]            mul_sum;
   logic [TS_W:0]          shifted, trial;
   logic [QW-1:0]          quot_eff;
   logic signed [rprm_pkg::SUM_W-1:0] rate_sum;
   logic                   rate_sat;

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rate_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_ok_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rprm_pkg::ST_IDLE: begin
            if (req_fire && req_tuser == rprm_pkg::ACT_READ) state_in = rprm_pkg::ST_LOAD;
         end
         rprm_pkg::ST_LOAD: begin
            if (pulse_cnt_ff > P'(1) && interval != '0) state_in = rprm_pkg::ST_MUL;
            else state_in = rprm_pkg::ST_DONE;
         end
         rprm_pkg::ST_MUL: begin
            if (step_ff == '0) state_in = rprm_pkg::ST_DIV;
         end
         rprm_pkg::ST_DIV: begin
            if (step_ff == '0) state_in = rprm_pkg::ST_DONE;
         end
         rprm_pkg::ST_DONE: begin
            if (out_free) state_in = rprm_pkg::ST_IDLE;
         end
         default: state_in = rprm_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      unique case (state_ff)
         rprm_pkg::ST_IDLE: req_tready = 1'b1;
         default:           req_tready = 1'b0;
      endcase
   end

   // Timestamps and interval, used in the load cycle.
   always_comb begin
      ovf_last_mul  = 17'(last_ovf_ff) * 17'(tpo_ff);
      ovf_first_mul = 17'(first_ovf_ff) * 17'(tpo_ff);
      ts_last  = ovf_last_mul[TS_W-1:0] + TS_W'(last_tick_ff);
      ts_first = ovf_first_mul[TS_W-1:0] + TS_W'(first_tick_ff);
      interval = ts_last - ts_first;
   end

   // One multiply step and one divide step.
   always_comb begin
      mul_sum = {1'b0, prod_ff[NW-1:P]} + (prod_ff[0] ? {1'b0, scale_ff} : '0);
      shifted = {rem_ff, prod_ff[NW-1]};
      trial   = shifted - {1'b0, div_ff};
   end

   // Offset add and saturation. A quotient beyond the tracked range always saturates.
   always_comb begin
      quot_eff = qbig_ff ? {1'b1, {(QW-1){1'b0}}} : quot_ff;
      rate_sum = $signed({2'b00, quot_eff})
               + $signed({{(rprm_pkg::SUM_W-rprm_pkg::OFFSET_W){offset_ff[31]}}, offset_ff});
      rate_sat = qbig_ff || (!rate_sum[rprm_pkg::SUM_W-1]
                             && rate_sum[rprm_pkg::SUM_W-2:rprm_pkg::RATE_W-1] != '0);
   end

   // Datapath next values.
   always_comb begin
      pulse_cnt_in  = pulse_cnt_ff;
      first_tick_in = first_tick_ff;
      first_ovf_in  = first_ovf_ff;
      last_tick_in  = last_tick_ff;
      last_ovf_in   = last_ovf_ff;
      scale_in      = scale_ff;
      div_in        = div_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      qbig_in       = qbig_ff;
      res_ok_in     = res_ok_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_rate_in   = rsp_rate_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_sat_in    = rsp_sat_ff;

      if (req_fire) begin
         case (req_tuser)
            rprm_pkg::ACT_PULSE: begin
               if (pulse_cnt_ff != '1) pulse_cnt_in = pulse_cnt_ff + P'(1);
               if (pulse_cnt_ff == '0) begin
                  first_tick_in = req_tdata[7:0];
                  first_ovf_in  = req_tdata[15:8];
               end else begin
                  last_tick_in = req_tdata[7:0];
                  last_ovf_in  = req_tdata[15:8];
               end
            end
            rprm_pkg::ACT_RESTART: begin
               pulse_cnt_in  = '0;
               first_tick_in = '0;
               first_ovf_in  = '0;
               last_tick_in  = '0;
               last_ovf_in   = '0;
            end
            default: ;
         endcase
      end

      case (state_ff)
         rprm_pkg::ST_LOAD: begin
            scale_in  = SW'(gain_ff * RATE_CONST_EXT);
            div_in    = interval;
            prod_in   = NW'(pulse_cnt_ff - P'(1));
            rem_in    = '0;
            quot_in   = '0;
            qbig_in   = 1'b0;
            res_ok_in = pulse_cnt_ff > P'(1) && interval != '0;
            step_in   = CNT_W'(P - 1);
         end
         rprm_pkg::ST_MUL: begin
            prod_in = {mul_sum, prod_ff[P-1:1]};
            step_in = (step_ff == '0) ? CNT_W'(NW - 1) : step_ff - CNT_W'(1);
         end
         rprm_pkg::ST_DIV: begin
            prod_in = {prod_ff[NW-2:0], 1'b0};
            quot_in = {quot_ff[QW-2:0], !trial[TS_W]};
            qbig_in = qbig_ff || quot_ff[QW-1];
            rem_in  = trial[TS_W] ? shifted[TS_W-1:0] : trial[TS_W-1:0];
            step_in = step_ff - CNT_W'(1);
         end
         rprm_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_sat_in   = res_ok_ff && rate_sat;
               if (!res_ok_ff) rsp_rate_in = '0;
               else if (rate_sat) rsp_rate_in = rprm_pkg::RATE_MAX;
               else rsp_rate_in = rate_sum[rprm_pkg::RATE_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // Registers written through the register channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= rprm_pkg::GAIN_W'(65536);
         offset_ff <= '0;
         tpo_ff    <= rprm_pkg::TPO_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rprm_pkg::CSR_FLOW_GAIN:   gain_ff   <= csr_data[rprm_pkg::GAIN_W-1:0];
            rprm_pkg::CSR_FLOW_OFFSET: offset_ff <= $signed(csr_data);
            rprm_pkg::CSR_TICKS_OVF:   tpo_ff    <= csr_data[rprm_pkg::TPO_W-1:0];
            default: ;
         endcase
      end
   end

   // Control and pulse state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rprm_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pulse_cnt_ff  <= '0;
         first_tick_ff <= '0;
         first_ovf_ff  <= '0;
         last_tick_ff  <= '0;
         last_ovf_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pulse_cnt_ff  <= pulse_cnt_in;
         first_tick_ff <= first_tick_in;
         first_ovf_ff  <= first_ovf_in;
         last_tick_ff  <= last_tick_in;
         last_ovf_ff   <= last_ovf_in;
      end
   end

   // Arithmetic and result payload.
   always_ff @(posedge clock) begin
      scale_ff    <= scale_in;
      div_ff      <= div_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      qbig_ff     <= qbig_in;
      res_ok_ff   <= res_ok_in;
      step_ff     <= step_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // The divide remainder stays below the divisor.
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == rprm_pkg::ST_DIV |-> rem_ff < div_ff)
      else $error("divide remainder not below divisor");

   // An accepted pulse never leaves the count at zero.
   a_pulse_counted: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == rprm_pkg::ACT_PULSE |=> pulse_cnt_ff != '0)
      else $error("pulse count wrapped");

   // A rate that is not valid is zero and not saturated.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("invalid rate not cleared");

   // A saturated rate sits at the positive limit.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tdata == rprm_pkg::RATE_MAX)
      else $error("saturated rate not at limit");

endmodule
